// ===== hdl/fbc_pkg.sv =====
// Shared types, widths and plane extraction for the frustum box cull core.
`default_nettype none

package fbc_pkg;

  // Number of frustum planes and matrix register pairs
  localparam int NUM_PLANES = 6;
  localparam int NUM_PAIRS  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Widths of a matrix entry, a plane coefficient and the exact accumulator
  localparam int ENTRY_W = 32;
  localparam int N_W     = ENTRY_W + 1;
  localparam int PROD_W  = N_W + ENTRY_W;
  localparam int HN_W    = 64;
  localparam int ACC_W   = 68;

  typedef logic [NUM_PAIRS-1:0][CFG_DATA_W-1:0] matrix_t;

  // One box as it travels along the chain
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        hx;
    logic [30:0]        hy;
    logic [30:0]        hz;
  } box_t;

  // One plane: normal and offset, not normalised
  typedef struct packed {
    logic signed [N_W-1:0] nx;
    logic signed [N_W-1:0] ny;
    logic signed [N_W-1:0] nz;
    logic signed [N_W-1:0] d;
  } plane_t;

  // Pick matrix entry e (column-major) out of the register pairs
  function automatic logic signed [ENTRY_W-1:0] entry(matrix_t m, int e);
    logic [CFG_DATA_W-1:0] w;
    begin
      w = m[CFG_IDX_W'(e >> 1)];
      entry = $signed(w[6'((e & 1) * ENTRY_W) +: ENTRY_W]);
    end
  endfunction

  // Sum or difference of two entries, exact in one extra bit
  function automatic logic signed [N_W-1:0] comb(logic signed [ENTRY_W-1:0] a,
                                                 logic signed [ENTRY_W-1:0] b,
                                                 logic minus);
    logic signed [N_W-1:0] ax;
    logic signed [N_W-1:0] bx;
    begin
      ax = N_W'(a);
      bx = N_W'(b);
      comb = minus ? (ax - bx) : (ax + bx);
    end
  endfunction

  // Form plane p from row 3 plus or minus row p/2
  function automatic plane_t plane_of(matrix_t m, int p);
    int     j;
    logic   minus;
    plane_t pl;
    begin
      j     = p >> 1;
      minus = (p & 1) != 0;
      pl.nx = comb(entry(m, 3),  entry(m, j),      minus);
      pl.ny = comb(entry(m, 7),  entry(m, j + 4),  minus);
      pl.nz = comb(entry(m, 11), entry(m, j + 8),  minus);
      pl.d  = comb(entry(m, 15), entry(m, j + 12), minus);
      plane_of = pl;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fbc_cell.sv =====
// One plane test cell: four pipeline stages that test the passing box against one plane.
`default_nettype none

module fbc_cell #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire fbc_pkg::plane_t plane,
  input  wire logic          in_v,
  input  wire fbc_pkg::box_t in_box,
  input  wire logic          in_culled,
  output logic               out_v,
  output fbc_pkg::box_t      out_box,
  output logic               out_culled
);

  localparam int N_W    = fbc_pkg::N_W;
  localparam int PROD_W = fbc_pkg::PROD_W;
  localparam int HN_W   = fbc_pkg::HN_W;
  localparam int ACC_W  = fbc_pkg::ACC_W;

  logic signed [N_W-1:0]   n [3];
  logic [N_W-1:0]          nmag [3];
  logic signed [31:0]      c [3];
  logic [30:0]             h [3];
  logic signed [ACC_W-1:0] d_ext;

  // Stage one: products
  logic                     v1;
  fbc_pkg::box_t            box1;
  logic                     cul1;
  logic signed [PROD_W-1:0] nc [3];
  logic [HN_W-1:0]          hn [3];
  logic signed [ACC_W-1:0]  dd1;

  // Stage two: per-axis sums
  logic                    v2;
  fbc_pkg::box_t           box2;
  logic                    cul2;
  logic signed [ACC_W-1:0] t [3];
  logic signed [ACC_W-1:0] dd2;

  // Stage three: pair sums
  logic                    v3;
  fbc_pkg::box_t           box3;
  logic                    cul3;
  logic signed [ACC_W-1:0] u0;
  logic signed [ACC_W-1:0] u1;
  logic signed [ACC_W-1:0] total;

  assign n[0] = plane.nx;
  assign n[1] = plane.ny;
  assign n[2] = plane.nz;
  assign c[0] = in_box.cx;
  assign c[1] = in_box.cy;
  assign c[2] = in_box.cz;
  assign h[0] = in_box.hx;
  assign h[1] = in_box.hy;
  assign h[2] = in_box.hz;
  assign d_ext = ACC_W'(plane.d);
  assign total = u0 + u1;

  // Magnitude of each normal component; the most negative value still fits unsigned
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nmag[k] = n[k][N_W-1] ? N_W'(-n[k]) : N_W'(n[k]);
    end
  end

  // Hold the valid bits; clear them on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      v3    <= v2;
      out_v <= v3;
    end
  end

  // Advance the payload through the four stages
  always_ff @(posedge clk) begin
    if (en) begin
      box1 <= in_box;
      cul1 <= in_culled;
      for (int k = 0; k < 3; k++) begin
        nc[k] <= PROD_W'(n[k]) * PROD_W'(c[k]);
        hn[k] <= HN_W'(nmag[k]) * HN_W'(h[k]);
      end
      dd1 <= d_ext <<< FRAC_BITS;

      box2 <= box1;
      cul2 <= cul1;
      for (int k = 0; k < 3; k++) begin
        t[k] <= ACC_W'(nc[k]) + $signed(ACC_W'(hn[k]));
      end
      dd2 <= dd1;

      box3 <= box2;
      cul3 <= cul2;
      u0   <= t[0] + t[1];
      u1   <= t[2] + dd2;

      out_box    <= box3;
      out_culled <= cul3 | total[ACC_W-1];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/frustum_box_cull_core.sv =====
// Top level of the frustum box cull core: matrix registers, plane set-up and the cell chain.
//
//  Channel   Signals                                  Direction
//  config    cfg_we, cfg_index, cfg_data              in
//  box in    in_valid, in_stall, center_*, half_*     in (in_stall out)
//  result    out_valid, out_stall, visible            out (out_stall in)
//
// One box per cycle is taken while in_stall is low; six plane cells of four stages each
// form the chain, and a finished box passes from the chain into the output register.
// Reset loads the identity matrix and empties the chain and output stage.
// A result held by out_stall stays in the output register; one more item lands in
// the skid register, and while that is full the chain freezes and in_stall is high.
`default_nettype none

module frustum_box_cull_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [fbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fbc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [31:0]                 center_x,
  input  wire logic signed [31:0]                 center_y,
  input  wire logic signed [31:0]                 center_z,
  input  wire logic [30:0]                        half_x,
  input  wire logic [30:0]                        half_y,
  input  wire logic [30:0]                        half_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    visible
);

  localparam int NP = fbc_pkg::NUM_PLANES;
  localparam logic [fbc_pkg::CFG_DATA_W-1:0] ONE =
    fbc_pkg::CFG_DATA_W'(1) << FRAC_BITS;
  localparam logic [fbc_pkg::CFG_DATA_W-1:0] ZERO = '0;
  localparam fbc_pkg::matrix_t MATRIX_RESET =
    {ONE << 32, ZERO, ONE, ZERO, ZERO, ONE << 32, ZERO, ONE};

  fbc_pkg::matrix_t matrix;
  fbc_pkg::plane_t  planes [NP];

  logic           en;
  logic           chain_v   [NP+1];
  fbc_pkg::box_t  chain_box [NP+1];
  logic           chain_cul [NP+1];

  logic skid_valid;
  logic skid_visible;
  logic out_free;

  // Write the matrix registers; reset to identity
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= MATRIX_RESET;
    end else if (cfg_we) begin
      matrix[cfg_index] <= cfg_data;
    end
  end

  // Form the six planes from the matrix rows
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      planes[p] = fbc_pkg::plane_of(matrix, p);
    end
  end

  // Feed the chain; it advances while the skid register is empty
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  assign chain_v[0]      = in_valid;
  assign chain_cul[0]    = 1'b0;
  assign chain_box[0].cx = center_x;
  assign chain_box[0].cy = center_y;
  assign chain_box[0].cz = center_z;
  assign chain_box[0].hx = half_x;
  assign chain_box[0].hy = half_y;
  assign chain_box[0].hz = half_z;

  for (genvar p = 0; p < NP; p++) begin : g_cell
    fbc_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .plane      (planes[p]),
      .in_v       (chain_v[p]),
      .in_box     (chain_box[p]),
      .in_culled  (chain_cul[p]),
      .out_v      (chain_v[p+1]),
      .out_box    (chain_box[p+1]),
      .out_culled (chain_cul[p+1])
    );
  end

  assign out_free = !out_valid || !out_stall;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        visible    <= skid_visible;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= chain_v[NP];
        visible   <= !chain_cul[NP];
      end
    end else if (chain_v[NP] && !skid_valid) begin
      skid_valid   <= 1'b1;
      skid_visible <= !chain_cul[NP];
    end
  end

  // The skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full with no result in the output register");

  // A finished item meeting a held result drops into the skid entry
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && chain_v[NP] && !skid_valid) |=> skid_valid)
    else $error("finished item lost while output stalled");

  // A frozen chain keeps its finished item
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && chain_v[NP]) |=> chain_v[NP])
    else $error("chain dropped an item while frozen");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid))
    else $error("output stage not empty after reset");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the frustum box cull core: random and directed boxes.
`timescale 1ns / 100ps

module tb;

  localparam int FRAC        = 16;
  localparam int ONE         = 1 << FRAC;
  localparam int SETTLE      = 40;    // pipeline depth plus margin
  localparam int IDLE_LIMIT  = 3000;  // cycles with no handshake before giving up

  localparam logic [31:0] MAX_C = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_C = 32'h8000_0000;
  localparam logic [31:0] MAX_H = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              cfg_we    = 1'b0;
  logic [fbc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [fbc_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_stall;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              visible;
  fbc_pkg::box_t                     cur_box   = '0;

  // Predictor state: a copy of the matrix registers as last written
  fbc_pkg::matrix_t   mat_regs;
  logic [31:0]        ent [16];

  fbc_pkg::box_t      pending_boxes [$];
  bit                 expected_visible [$];
  bit                 box_taken  = 1'b0;
  int                 gap_left   = 0;
  int                 stall_left = 0;
  int                 gap_pct    = 0;
  int                 stall_pct  = 0;
  int                 errors     = 0;
  int                 idle_cycles = 0;

  frustum_box_cull_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .center_x  (cur_box.cx),
    .center_y  (cur_box.cy),
    .center_z  (cur_box.cz),
    .half_x    (cur_box.hx),
    .half_y    (cur_box.hy),
    .half_z    (cur_box.hz),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .visible   (visible)
  );

  always #5 clk = ~clk;

  // Plane coefficient: entry e_base plus or minus entry e_other, widened
  function automatic logic signed [127:0] plane_coef(int e_base, int e_other, bit minus);
    logic signed [31:0]  a;
    logic signed [31:0]  b;
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    begin
      a  = mat_regs[3'(e_base / 2)][6'((e_base % 2) * 32) +: 32];
      b  = mat_regs[3'(e_other / 2)][6'((e_other % 2) * 32) +: 32];
      wa = 128'(a);
      wb = 128'(b);
      return minus ? wa - wb : wa + wb;
    end
  endfunction

  // Exact six-plane test: culled when n.c + d + sum(h|n|) goes negative for any plane
  function automatic bit box_in_frustum(fbc_pkg::box_t b);
    logic signed [127:0] acc;
    logic signed [127:0] n;
    logic signed [127:0] nabs;
    logic signed [127:0] c [3];
    logic signed [127:0] h [3];
    logic signed [127:0] d;
    bit                  vis;
    int                  j;
    begin
      vis  = 1'b1;
      c[0] = 128'(b.cx);
      c[1] = 128'(b.cy);
      c[2] = 128'(b.cz);
      h[0] = {97'b0, b.hx};
      h[1] = {97'b0, b.hy};
      h[2] = {97'b0, b.hz};
      for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
        j   = p / 2;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          n    = plane_coef(3 + 4 * k, j + 4 * k, p % 2 == 1);
          nabs = (n < 0) ? -n : n;
          acc  = acc + n * c[k] + nabs * h[k];
        end
        d   = plane_coef(15, 12 + j, p % 2 == 1);
        acc = acc + (d <<< FRAC);
        if (acc < 0)
          vis = 1'b0;
      end
      return vis;
    end
  endfunction

  // Gap length: none unless a pct-percent draw hits, then mostly short, a few long
  function automatic int pick_gap(int pct);
    begin
      if ($urandom_range(99) >= pct)
        return 0;
      if ($urandom_range(9) == 0)
        return $urandom_range(60, 20);
      return $urandom_range(3, 1);
    end
  endfunction

  function automatic logic [31:0] srand(int lim);
    begin
      return 32'($urandom_range(2 * lim)) - 32'(lim);
    end
  endfunction

  // Sender: hold a stalled item, otherwise idle or present the next one
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !box_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_boxes.size() > 0) begin
        cur_box  <= pending_boxes.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap(gap_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap(stall_pct);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on each accepted box, check each accepted result
  always @(posedge clk) begin
    bit want;
    box_taken <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      expected_visible = {expected_visible, box_in_frustum(cur_box)};
    if (!rst && out_valid && !out_stall) begin
      if (expected_visible.size() == 0) begin
        errors++;
        $display("%0t: result with no box pending, expected none, got visible=%0b",
                 $time, visible);
      end else begin
        want = expected_visible.pop_front();
        if (visible !== want) begin
          errors++;
          $display("%0t: visible mismatch, expected %0b, got %0b", $time, want, visible);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_visible.size());
      $display("status: fail");
      $finish;
    end
  end

  // Write all eight matrix pairs from ent[], back to back
  task automatic load_entries();
    for (int r = 0; r < fbc_pkg::NUM_PAIRS; r++) begin
      @(negedge clk);
      cfg_we      <= 1'b1;
      cfg_index   <= 3'(r);
      cfg_data    <= {ent[2 * r + 1], ent[2 * r]};
      mat_regs[r] = {ent[2 * r + 1], ent[2 * r]};
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_entries(logic [31:0] v);
    for (int i = 0; i < 16; i++)
      ent[i] = v;
  endtask

  task automatic push_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    fbc_pkg::box_t b;
    b.cx = cx;
    b.cy = cy;
    b.cz = cz;
    b.hx = hx[30:0];
    b.hy = hy[30:0];
    b.hz = hz[30:0];
    pending_boxes = {pending_boxes, b};
  endtask

  // Let the sender run dry, wait for every result, then let the pipe settle
  task automatic wait_drained();
    while (pending_boxes.size() != 0 || in_valid || expected_visible.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // One random phase: new matrix in the given style, then a burst of boxes
  task automatic run_random_phase(int style, int count);
    int c_lim;
    int h_lim;
    c_lim = 4 * ONE;
    h_lim = ONE;
    case (style)
      0: begin
        for (int i = 0; i < 16; i++)
          ent[i] = $urandom;
      end
      1: begin
        // scaled identity with a little noise: a box-shaped frustum
        for (int i = 0; i < 16; i++)
          ent[i] = srand(ONE / 8);
        ent[0]  = $urandom_range(4 * ONE, ONE / 4);
        ent[5]  = $urandom_range(4 * ONE, ONE / 4);
        ent[10] = $urandom_range(4 * ONE, ONE / 4);
        ent[15] = ONE;
      end
      default: begin
        for (int i = 0; i < 16; i++)
          ent[i] = srand(2 * ONE);
      end
    endcase
    load_entries();
    gap_pct   = pick_pct();
    stall_pct = pick_pct();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(4) == 0)
        push_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        push_box(srand(c_lim), srand(c_lim), srand(c_lim),
                 $urandom_range(h_lim), $urandom_range(h_lim),
                 $urandom_range(h_lim));
    end
    wait_drained();
  endtask

  initial begin
    // Reset matrix is the identity
    fill_entries('0);
    ent[0]  = ONE;
    ent[5]  = ONE;
    ent[10] = ONE;
    ent[15] = ONE;
    for (int r = 0; r < fbc_pkg::NUM_PAIRS; r++)
      mat_regs[r] = {ent[2 * r + 1], ent[2 * r]};

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Identity frustum: touching planes exactly, just outside, field extremes
    gap_pct   = 30;
    stall_pct = 30;
    push_box(0, 0, 0, 0, 0, 0);
    push_box(-2 * ONE, 0, 0, ONE, 0, 0);
    push_box(-2 * ONE - 1, 0, 0, ONE, 0, 0);
    push_box(2 * ONE, 0, 0, ONE, 0, 0);
    push_box(2 * ONE + 1, 0, 0, ONE, 0, 0);
    push_box(0, ONE, 0, 0, 0, 0);
    push_box(0, 0, -ONE - 1, 0, 0, 0);
    push_box(MAX_C, MAX_C, MAX_C, MAX_H, MAX_H, MAX_H);
    push_box(MIN_C, MIN_C, MIN_C, 0, 0, 0);
    push_box(MIN_C, MIN_C, MIN_C, MAX_H, MAX_H, MAX_H);
    push_box(MAX_C, 0, 0, 0, 0, 0);
    push_box(-1, -1, -1, MAX_H, 0, MAX_H);
    wait_drained();

    // Zero normals everywhere: offset alone decides, negative culls
    fill_entries('0);
    ent[15] = -ONE;
    load_entries();
    push_box(0, 0, 0, 0, 0, 0);
    push_box(MAX_C, MIN_C, MAX_C, MAX_H, MAX_H, MAX_H);
    wait_drained();
    ent[15] = '0;
    load_entries();
    push_box(MIN_C, MIN_C, MIN_C, MAX_H, MAX_H, MAX_H);
    wait_drained();

    // Extreme matrix entries
    fill_entries(32'hFFFF_FFFF);
    load_entries();
    push_box(MAX_C, MAX_C, MAX_C, 0, 0, 0);
    push_box(MIN_C, MIN_C, MIN_C, MAX_H, MAX_H, MAX_H);
    wait_drained();
    fill_entries(MIN_C);
    load_entries();
    push_box(MAX_C, MIN_C, MAX_C, MAX_H, 0, MAX_H);
    push_box(MIN_C, MAX_C, MIN_C, 0, MAX_H, 0);
    wait_drained();
    fill_entries(MAX_C);
    load_entries();
    push_box(MAX_C, MAX_C, MAX_C, MAX_H, MAX_H, MAX_H);
    push_box(MIN_C, MIN_C, MIN_C, 0, 0, 0);
    wait_drained();

    // Random matrices and boxes
    for (int ph = 0; ph < 8; ph++)
      run_random_phase(ph % 3, 160);

    if (expected_visible.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_visible.size());
    end
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
